// ===== rtl/chord_key_resolver_assert.svh =====
// Assertion macros for the chord key resolver RTL, included by ckr_serializer.
// Each macro expands to one labeled concurrent assertion that is disabled during reset.
`ifndef CHORD_KEY_RESOLVER_ASSERT_SVH
`define CHORD_KEY_RESOLVER_ASSERT_SVH

// Same-cycle implication: the consequent must hold in the cycle of the antecedent.
`define CKR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define CKR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ckr_pkg.sv =====
package ckr_pkg;

   // Grid and note range constants.
   localparam int unsigned NUM_COLS    = 12;
   localparam int unsigned ADD9_OFFSET = 14;
   localparam int unsigned NOTE_MAX    = 127;
   localparam logic [6:0]  BASE_ROOT_RESET = 7'd48;

   typedef logic [NUM_COLS-1:0] col_mask_type;

   // Chord type codes as they appear on the result channel.
   typedef enum logic [3:0] {
      CHORD_MAJOR  = 4'd0,
      CHORD_MINOR  = 4'd1,
      CHORD_DOM7   = 4'd2,
      CHORD_MAJ7   = 4'd3,
      CHORD_MIN7   = 4'd4,
      CHORD_DIM    = 4'd5,
      CHORD_DIM7   = 4'd6,
      CHORD_AUG    = 4'd7,
      CHORD_SUS4   = 4'd8,
      CHORD_SUS2   = 4'd9,
      CHORD_MIN7B5 = 4'd10
   } chord_type_type;

   // Signed note arithmetic covers -96 .. 236 before clamping.
   typedef logic signed [8:0] note_calc_type;

   // One captured key snapshot.
   typedef struct packed {
      col_mask_type       major_keys;
      col_mask_type       minor_keys;
      col_mask_type       seventh_keys;
      logic               backtick_held;
      logic signed [3:0]  octave_shift;
   } req_item_type;

   // A resolved chord, ready to be serialized into notes.
   typedef struct packed {
      logic           found;
      logic [3:0]     root_class;
      chord_type_type chord_type;
      logic           add_ninth;
      note_calc_type  root;
      logic [1:0]     last_index;
   } chord_desc_type;

   // One result item.
   typedef struct packed {
      logic           found;
      logic [3:0]     root_class;
      chord_type_type chord_type;
      logic           add_ninth;
      logic [6:0]     note;
      logic           last;
   } rsp_item_type;

   // Root pitch class of each column, in circle-of-fifths order starting at D flat.
   function automatic logic [3:0] column_pitch_class(input logic [3:0] col);
      logic [3:0] pc;
      case (col)
         4'd0:    pc = 4'd1;
         4'd1:    pc = 4'd8;
         4'd2:    pc = 4'd3;
         4'd3:    pc = 4'd10;
         4'd4:    pc = 4'd5;
         4'd5:    pc = 4'd0;
         4'd6:    pc = 4'd7;
         4'd7:    pc = 4'd2;
         4'd8:    pc = 4'd9;
         4'd9:    pc = 4'd4;
         4'd10:   pc = 4'd11;
         4'd11:   pc = 4'd6;
         default: pc = 4'd0;
      endcase
      return pc;
   endfunction

   // Intervals above the root, one nibble per chord tone, lowest tone in the low nibble.
   function automatic logic [15:0] chord_intervals(input chord_type_type ctype);
      logic [15:0] ivs;
      case (ctype)
         CHORD_MAJOR:  ivs = 16'h0740;
         CHORD_MINOR:  ivs = 16'h0730;
         CHORD_DOM7:   ivs = 16'hA740;
         CHORD_MAJ7:   ivs = 16'hB740;
         CHORD_MIN7:   ivs = 16'hA730;
         CHORD_DIM:    ivs = 16'h0630;
         CHORD_DIM7:   ivs = 16'h9630;
         CHORD_AUG:    ivs = 16'h0840;
         CHORD_SUS4:   ivs = 16'h0750;
         CHORD_SUS2:   ivs = 16'h0720;
         CHORD_MIN7B5: ivs = 16'hA630;
         default:      ivs = 16'h0000;
      endcase
      return ivs;
   endfunction

   // Index of the final chord tone, before any added ninth.
   function automatic logic [1:0] chord_last_index(input chord_type_type ctype);
      logic [1:0] idx;
      case (ctype)
         CHORD_DOM7, CHORD_MAJ7, CHORD_MIN7, CHORD_DIM7, CHORD_MIN7B5: idx = 2'd3;
         default: idx = 2'd2;
      endcase
      return idx;
   endfunction

endpackage

// ===== rtl/ckr_req_if.sv =====
interface ckr_req_if;
   logic                   valid;
   logic                   ready;
   ckr_pkg::col_mask_type  major_keys;
   ckr_pkg::col_mask_type  minor_keys;
   ckr_pkg::col_mask_type  seventh_keys;
   logic                   backtick_held;
   logic signed [3:0]      octave_shift;

   modport source (
      output valid, major_keys, minor_keys, seventh_keys, backtick_held, octave_shift,
      input  ready
   );
   modport sink (
      input  valid, major_keys, minor_keys, seventh_keys, backtick_held, octave_shift,
      output ready
   );
endinterface

// ===== rtl/ckr_rsp_if.sv =====
interface ckr_rsp_if;
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [3:0]              root_class;
   logic [3:0]              chord_type;
   logic                    add_ninth;
   logic [6:0]              note;
   logic                    last;

   modport source (
      output valid, found, root_class, chord_type, add_ninth, note, last,
      input  ready
   );
   modport sink (
      input  valid, found, root_class, chord_type, add_ninth, note, last,
      output ready
   );
endinterface

// ===== rtl/ckr_csr_if.sv =====
interface ckr_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] base_root_note;

   modport source (
      output valid, base_root_note,
      input  ready
   );
   modport sink (
      input  valid, base_root_note,
      output ready
   );
endinterface

// ===== rtl/chord_key_resolver.sv =====
// Chord key resolver.
// req_bus carries one key snapshot per transfer: major, minor and seventh column
// bitmaps, the backtick modifier and a signed octave shift. rsp_bus returns the
// chord's notes in ascending order, one transfer per note, with last set on the
// final one; a snapshot that names no chord yields one transfer with found cleared.
// csr_bus writes base_root_note and is always ready; write it only while idle.
// The first note of a snapshot passes the input, chord and output registers in turn.
// Throughput: one note per cycle while the receiver does not stall, so a snapshot
// spans one to four transfers on the result side, set by the note count of its
// chord, which the single output register shifts out one tone at a time. A new
// snapshot is taken while the previous chord is still being emitted.
// Reset clears all valid flags and sets base_root_note to 48.
// When the receiver stalls, the output register holds its note, the chord
// register holds its place, and once the input register is full req_bus.ready
// drops until the stall clears.
module chord_key_resolver (
   input  logic         clock,
   input  logic         reset,
   ckr_req_if.sink      req_bus,
   ckr_rsp_if.source    rsp_bus,
   ckr_csr_if.sink      csr_bus
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   ckr_pkg::req_item_type   in_item_ff;
   ckr_pkg::req_item_type   in_item_in;
   logic [6:0]              base_ff;
   logic [6:0]              base_in;

   logic                    req_transfer;
   logic                    ser_ready;
   ckr_pkg::chord_desc_type desc;
   ckr_pkg::rsp_item_type   out_item;
   logic                    out_valid;

   // Input register: refills as soon as its snapshot moves on.
   always_comb begin
      req_bus.ready = !in_valid_ff || ser_ready;
      req_transfer  = req_bus.valid && req_bus.ready;
      in_valid_in   = req_transfer || (in_valid_ff && !ser_ready);
      in_item_in    = in_item_ff;
      if (req_transfer) begin
         in_item_in.major_keys    = req_bus.major_keys;
         in_item_in.minor_keys    = req_bus.minor_keys;
         in_item_in.seventh_keys  = req_bus.seventh_keys;
         in_item_in.backtick_held = req_bus.backtick_held;
         in_item_in.octave_shift  = req_bus.octave_shift;
      end
   end

   // Configuration register.
   always_comb begin
      csr_bus.ready = 1'b1;
      base_in       = csr_bus.valid ? csr_bus.base_root_note : base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         base_ff     <= ckr_pkg::BASE_ROOT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         base_ff     <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   ckr_resolver u_resolver (
      .item           (in_item_ff),
      .base_root_note (base_ff),
      .desc           (desc)
   );

   ckr_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_desc   (desc),
      .in_ready  (ser_ready),
      .out_valid (out_valid),
      .out_item  (out_item),
      .out_ready (rsp_bus.ready)
   );

   // Result channel driven straight from the output register.
   always_comb begin
      rsp_bus.valid      = out_valid;
      rsp_bus.found      = out_item.found;
      rsp_bus.root_class = out_item.root_class;
      rsp_bus.chord_type = out_item.chord_type;
      rsp_bus.add_ninth  = out_item.add_ninth;
      rsp_bus.note       = out_item.note;
      rsp_bus.last       = out_item.last;
   end

endmodule

// ===== rtl/ckr_resolver.sv =====
module ckr_resolver (
   input  ckr_pkg::req_item_type   item,
   input  logic [6:0]              base_root_note,
   output ckr_pkg::chord_desc_type desc
);

   ckr_pkg::col_mask_type   cols;
   logic                    single_col;
   logic [3:0]              first_col;
   logic                    ma_here;
   logic                    mi_here;
   logic                    se_here;
   logic [10:0]             sus_hits;
   logic [10:0]             add_hits;
   logic [10:0]             sus_low;
   logic [10:0]             add_low;
   logic [3:0]              sus_col;
   logic [3:0]              add_col;
   logic                    found;
   logic [3:0]              col;
   ckr_pkg::chord_type_type ctype;
   logic                    add9;
   logic [3:0]              pc;
   ckr_pkg::note_calc_type  oct_ext;
   ckr_pkg::note_calc_type  oct_offset;
   ckr_pkg::note_calc_type  root;

   // Priority of quality combinations when one column is held.
   function automatic ckr_pkg::chord_type_type single_type(input logic ma, input logic mi,
                                                           input logic se);
      ckr_pkg::chord_type_type t;
      if (ma && mi && se) begin
         t = ckr_pkg::CHORD_AUG;
      end else if (ma && se) begin
         t = ckr_pkg::CHORD_MAJ7;
      end else if (mi && se) begin
         t = ckr_pkg::CHORD_MIN7;
      end else if (ma && mi) begin
         t = ckr_pkg::CHORD_DIM;
      end else if (se) begin
         t = ckr_pkg::CHORD_DOM7;
      end else if (mi) begin
         t = ckr_pkg::CHORD_MINOR;
      end else begin
         t = ckr_pkg::CHORD_MAJOR;
      end
      return t;
   endfunction

   // Held columns, whether exactly one is held, and which one.
   always_comb begin
      cols       = item.major_keys | item.minor_keys | item.seventh_keys;
      single_col = (cols != '0) && ((cols & (cols - 12'd1)) == '0);
      first_col  = 4'd0;
      for (int i = 0; i < ckr_pkg::NUM_COLS; i++) begin
         first_col = first_col | (cols[i] ? 4'(i) : 4'd0);
      end
      ma_here = |(item.major_keys & cols);
      mi_here = |(item.minor_keys & cols);
      se_here = |(item.seventh_keys & cols);
   end

   // Pairings of a major key with a seventh or minor key in the column to its left.
   // The lowest pairing wins, so isolate the lowest set bit and encode it.
   always_comb begin
      sus_hits = item.major_keys[11:1] & item.seventh_keys[10:0];
      add_hits = item.major_keys[11:1] & item.minor_keys[10:0];
      sus_low  = sus_hits & (~sus_hits + 11'd1);
      add_low  = add_hits & (~add_hits + 11'd1);
      sus_col  = 4'd0;
      add_col  = 4'd0;
      for (int i = 0; i < ckr_pkg::NUM_COLS - 1; i++) begin
         sus_col = sus_col | (sus_low[i] ? 4'(i + 1) : 4'd0);
         add_col = add_col | (add_low[i] ? 4'(i + 1) : 4'd0);
      end
   end

   // Chord selection.
   always_comb begin
      found = 1'b0;
      col   = 4'd0;
      ctype = ckr_pkg::CHORD_MAJOR;
      add9  = 1'b0;
      if (single_col) begin
         found = 1'b1;
         col   = first_col;
         if (item.backtick_held && cols[0] && item.major_keys[0]) begin
            ctype = ckr_pkg::CHORD_SUS4;
         end else if (item.backtick_held && cols[0] && item.minor_keys[0]) begin
            ctype = ckr_pkg::CHORD_MAJOR;
            add9  = 1'b1;
         end else begin
            ctype = single_type(ma_here, mi_here, se_here);
         end
      end else if (|sus_hits) begin
         found = 1'b1;
         col   = sus_col;
         ctype = ckr_pkg::CHORD_SUS4;
      end else if (|add_hits) begin
         found = 1'b1;
         col   = add_col;
         ctype = ckr_pkg::CHORD_MAJOR;
         add9  = 1'b1;
      end
   end

   // Root note: base plus pitch class plus twelve semitones per octave.
   always_comb begin
      pc         = ckr_pkg::column_pitch_class(col);
      oct_ext    = {{5{item.octave_shift[3]}}, item.octave_shift};
      oct_offset = (oct_ext <<< 3) + (oct_ext <<< 2);
      root       = $signed({2'b00, base_root_note}) + $signed({5'b00000, pc}) + oct_offset;
   end

   // An empty result carries zeros in every field but last.
   always_comb begin
      if (found) begin
         desc.found      = 1'b1;
         desc.root_class = pc;
         desc.chord_type = ctype;
         desc.add_ninth  = add9;
         desc.root       = root;
         desc.last_index = add9 ? 2'd3 : ckr_pkg::chord_last_index(ctype);
      end else begin
         desc.found      = 1'b0;
         desc.root_class = 4'd0;
         desc.chord_type = ckr_pkg::CHORD_MAJOR;
         desc.add_ninth  = 1'b0;
         desc.root       = '0;
         desc.last_index = 2'd0;
      end
   end

endmodule

// ===== rtl/ckr_serializer.sv =====
`include "chord_key_resolver_assert.svh"

module ckr_serializer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  ckr_pkg::chord_desc_type in_desc,
   output logic                    in_ready,
   output logic                    out_valid,
   output ckr_pkg::rsp_item_type   out_item,
   input  logic                    out_ready
);

   ckr_pkg::chord_desc_type desc_ff;
   ckr_pkg::chord_desc_type desc_in;
   logic                    desc_valid_ff;
   logic                    desc_valid_in;
   logic [1:0]              idx_ff;
   logic [1:0]              idx_in;
   ckr_pkg::rsp_item_type   out_ff;
   ckr_pkg::rsp_item_type   out_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;

   logic                    desc_last;
   logic                    out_load;
   logic                    desc_done;
   logic                    desc_load;
   logic [15:0]             ivs;
   logic [3:0]              interval;
   ckr_pkg::note_calc_type  note_sum;
   logic [6:0]              note_clamped;

   // Handshake between the chord holding register and the output register.
   always_comb begin
      desc_last = (idx_ff == desc_ff.last_index);
      out_load  = desc_valid_ff && (!out_valid_ff || out_ready);
      desc_done = out_load && desc_last;
      in_ready  = !desc_valid_ff || desc_done;
      desc_load = in_valid && in_ready;
   end

   // Note for the current tone, clamped to the MIDI range.
   always_comb begin
      ivs = ckr_pkg::chord_intervals(desc_ff.chord_type);
      if (desc_ff.add_ninth && (idx_ff == 2'd3)) begin
         interval = 4'(ckr_pkg::ADD9_OFFSET);
      end else begin
         interval = ivs[{idx_ff, 2'b00} +: 4];
      end
      note_sum = desc_ff.root + $signed({5'b00000, interval});
      if (note_sum < 0) begin
         note_clamped = 7'd0;
      end else if (note_sum > $signed(9'(ckr_pkg::NOTE_MAX))) begin
         note_clamped = 7'(ckr_pkg::NOTE_MAX);
      end else begin
         note_clamped = note_sum[6:0];
      end
   end

   // Next values of the holding register and the tone counter.
   always_comb begin
      desc_in       = desc_load ? in_desc : desc_ff;
      desc_valid_in = desc_load || (desc_valid_ff && !desc_done);
      if (desc_load) begin
         idx_in = 2'd0;
      end else if (out_load) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   // Next values of the output register.
   always_comb begin
      out_valid_in = out_load || (out_valid_ff && !out_ready);
      out_in       = out_ff;
      if (out_load) begin
         out_in.found      = desc_ff.found;
         out_in.root_class = desc_ff.root_class;
         out_in.chord_type = desc_ff.chord_type;
         out_in.add_ninth  = desc_ff.add_ninth;
         out_in.note       = note_clamped;
         out_in.last       = desc_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         desc_valid_ff <= desc_valid_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      out_ff  <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

   // Checks on the tone sequencing.
   `CKR_ASSERT_IMPL(a_idx_bound, clock, reset, desc_valid_ff, idx_ff <= desc_ff.last_index, "tone index beyond chord size")
   `CKR_ASSERT_NEXT(a_idx_step, clock, reset, out_load && !desc_last, idx_ff == $past(idx_ff) + 2'd1, "tone index did not advance")
   `CKR_ASSERT_NEXT(a_last_frees, clock, reset, desc_done && !in_valid, !desc_valid_ff, "chord held after its last tone")
   `CKR_ASSERT_IMPL(a_empty_single, clock, reset, desc_valid_ff && !desc_ff.found, desc_ff.last_index == 2'd0, "empty result spans several tones")
   `CKR_ASSERT_IMPL(a_empty_zero, clock, reset, out_valid_ff && !out_ff.found, out_ff.last && (out_ff.note == 7'd0), "empty result not a single zero note")

endmodule
